// File: hdl/ifps_pkg.sv
// ifps_pkg: shared constants and types for the ipv4 flow packet sampler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ifps_pkg;
   localparam logic [31:0] LCG_MUL = 32'd1103515245;
   localparam logic [31:0] LCG_ADD = 32'd12345;
   localparam logic [12:0] FRAG_MASK = 13'h1fff;
   localparam logic [31:0] DEFAULT_DIVISOR = 32'd100;
   localparam logic [6:0] ETH_LEN = 7'd14;
   localparam logic [6:0] POS_MAX = 7'd127;
   localparam logic [15:0] ETH_TYPE_IP = 16'h0800;
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;
   localparam logic CSR_DIVISOR = 1'b0;
   localparam logic CSR_IFACE = 1'b1;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic        has_link_header;
      logic        direction;
      logic [15:0] seg_count;
      logic [31:0] entropy;
      logic [31:0] time_low;
      logic [16:0] wire_length;
      logic [15:0] if_index;
   } req_type;

   typedef struct packed {
      logic        event_valid;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [15:0] ip_total_length;
      logic [7:0]  protocol_number;
      logic        event_direction;
      logic [15:0] event_segments;
      logic [63:0] packet_total;
      logic [63:0] byte_total;
      logic [63:0] sampled_total;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic parse;      // take one byte into the header parser
      logic finish;     // last byte: latch seed and side fields
      logic mul_go;     // mix source, destination and ports into the seed
      logic div_start;  // lcg multiply and start remainder
      logic emit;       // load response register
      logic rsp_pop;    // response taken
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic eligible;   // packet qualifies for a random draw
      logic keep_all;   // rate at most one
      logic div_done;
      logic rsp_full;
   } status_type;
endpackage
`default_nettype wire

// File: hdl/ifps_if.sv
// ifps_stream_if: valid/ready channel carrying one payload
// depends on nothing but the payload type parameter
`timescale 1ns / 1ps
`default_nettype none
interface ifps_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: hdl/ifps_datapath.sv
// ifps_datapath: header parser, counters, seed/lcg, serial remainder, response register
// depends on ifps_pkg
`timescale 1ns / 1ps
`default_nettype none
module ifps_datapath import ifps_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire req_type    req,
   input  wire logic       csr_write,
   input  wire logic [0:0] csr_index,
   input  wire logic [31:0] csr_data,
   input  wire cmd_type    cmd,
   output status_type      status,
   output rsp_type         rsp
);
   logic [31:0] divisor_ff;
   logic [15:0] iface_ff;
   logic [6:0]  pos_ff;
   logic [15:0] ltype_ff, frag_ff, dlen_ff;
   logic [7:0]  hdr_ff, proto_ff;
   logic [31:0] src_ff, dst_ff, ports_ff;
   logic        link_ff, ifok_ff, counted_ff;
   logic [63:0] pkts_ff, bytes_ff, samp_ff;
   logic        elig_ff, dir_ff;
   logic [15:0] segs_ff;
   logic [31:0] seed_ff, rnd_ff, rate_ff, rem_ff;
   logic [5:0]  bit_ff;
   logic        busy_ff, done_ff;
   rsp_type     rsp_ff;
   logic        full_ff;

   logic        link_in, ifok_in;
   logic [6:0]  base, off, n;
   logic [7:0]  hdr_in;
   logic [6:0]  ihl4, ihl4_in;
   logic        link_ok, count_now;
   logic [31:0] rate;
   logic [32:0] rem_sh;
   logic        hit;
   rsp_type     rsp_in;

   always_comb begin
      link_in = (pos_ff == 7'd0) ? req.has_link_header : link_ff;
      ifok_in = (pos_ff == 7'd0) ?
                ((iface_ff != 16'd0) && (req.if_index == iface_ff)) : ifok_ff;
      base = link_in ? ETH_LEN : 7'd0;
      off = pos_ff - base;
      ihl4 = {1'b0, hdr_ff[3:0], 2'b00};
      n = (pos_ff < POS_MAX) ? pos_ff + 7'd1 : pos_ff;
      hdr_in = (pos_ff < POS_MAX && pos_ff >= base && off == 7'd0) ? req.data_byte : hdr_ff;
      ihl4_in = {1'b0, hdr_in[3:0], 2'b00};
      link_ok = link_in ? ((pos_ff < POS_MAX && (pos_ff == 7'd13)) ?
                           ({ltype_ff[7:0], req.data_byte} == ETH_TYPE_IP) :
                           (ltype_ff == ETH_TYPE_IP))
                        : (ifok_in && hdr_in[7:4] == 4'd4);
      // n is pos+1 saturating; match needs exact arithmetic in 8 bits
      count_now = !counted_ff && link_ok && ihl4_in >= 7'd20 && pos_ff < POS_MAX &&
                  ({1'b0, pos_ff} + 8'd1 == {1'b0, base} + {1'b0, ihl4_in});
      rate = (divisor_ff == 32'd0) ? DEFAULT_DIVISOR : divisor_ff;
      rem_sh = {rem_ff, rnd_ff[bit_ff[4:0]]};
   end

   logic [7:0] tail;
   logic       elig_in;
   always_comb begin
      tail = {1'b0, n} ;
      elig_in = (counted_ff || count_now) && (frag_ff[12:0] & FRAG_MASK) == 13'd0 &&
         ((proto_ff == PROTO_TCP && {1'b0, n} >= {1'b0, base} + {1'b0, ihl4} + 8'd20) ||
          (proto_ff == PROTO_UDP && tail >= {1'b0, base} + {1'b0, ihl4} + 8'd8));
   end

   // response word for the packet that ends
   always_comb begin
      hit = elig_ff && (rate_ff <= 32'd1 || rem_ff == 32'd0);
      rsp_in = '0;
      if (hit) begin
         rsp_in.event_valid = 1'b1;
         rsp_in.source_address = src_ff;
         rsp_in.dest_address = dst_ff;
         rsp_in.source_port = ports_ff[31:16];
         rsp_in.dest_port = ports_ff[15:0];
         rsp_in.ip_total_length = dlen_ff;
         rsp_in.protocol_number = proto_ff;
         rsp_in.event_direction = dir_ff;
         rsp_in.event_segments = segs_ff;
         rsp_in.sampled_total = samp_ff + 64'd1;
      end else rsp_in.sampled_total = samp_ff;
      rsp_in.packet_total = pkts_ff;
      rsp_in.byte_total = bytes_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff <= '0; iface_ff <= '0;
         pos_ff <= '0; ltype_ff <= '0; frag_ff <= '0; dlen_ff <= '0;
         hdr_ff <= '0; proto_ff <= '0; src_ff <= '0; dst_ff <= '0; ports_ff <= '0;
         link_ff <= 1'b0; ifok_ff <= 1'b0; counted_ff <= 1'b0;
         pkts_ff <= '0; bytes_ff <= '0; samp_ff <= '0;
         busy_ff <= 1'b0; done_ff <= 1'b0; full_ff <= 1'b0; elig_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_DIVISOR) divisor_ff <= csr_data;
            else iface_ff <= csr_data[15:0];
         end
         if (cmd.parse) begin
            link_ff <= link_in;
            ifok_ff <= ifok_in;
            if (pos_ff < POS_MAX) begin
               if (link_in && (pos_ff == 7'd12 || pos_ff == 7'd13))
                  ltype_ff <= {ltype_ff[7:0], req.data_byte};
               if (pos_ff >= base) begin
                  if (off == 7'd0) hdr_ff <= req.data_byte;
                  else if (off == 7'd2 || off == 7'd3) dlen_ff <= {dlen_ff[7:0], req.data_byte};
                  else if (off == 7'd6 || off == 7'd7) frag_ff <= {frag_ff[7:0], req.data_byte};
                  else if (off == 7'd9) proto_ff <= req.data_byte;
                  else if (off >= 7'd12 && off < 7'd16)
                     src_ff[8*off[1:0] +: 8] <= req.data_byte;
                  else if (off >= 7'd16 && off < 7'd20)
                     dst_ff[8*off[1:0] +: 8] <= req.data_byte;
                  if (ihl4 >= 7'd20 && off >= ihl4 && {1'b0, off} < {1'b0, ihl4} + 8'd4)
                     ports_ff <= {ports_ff[23:0], req.data_byte};
               end
               pos_ff <= n;
            end
            if (count_now) begin
               counted_ff <= 1'b1;
               pkts_ff <= pkts_ff + 64'd1;
               bytes_ff <= bytes_ff + {47'd0, req.wire_length};
            end
            if (cmd.finish) begin
               elig_ff <= elig_in;
               dir_ff <= req.direction;
               segs_ff <= (req.seg_count == 16'd0) ? 16'd1 : req.seg_count;
               seed_ff <= req.entropy ^ req.time_low;
            end
         end
         if (cmd.mul_go) begin
            seed_ff <= seed_ff ^ src_ff ^ dst_ff ^ ports_ff;
         end
         if (cmd.div_start) begin
            rnd_ff <= seed_ff * LCG_MUL + LCG_ADD;
            rate_ff <= rate;
            rem_ff <= '0;
            bit_ff <= 6'd31;
            busy_ff <= 1'b1;
            done_ff <= 1'b0;
         end else if (busy_ff) begin
            rem_ff <= (rem_sh >= {1'b0, rate_ff}) ? 32'(rem_sh - {1'b0, rate_ff}) : rem_sh[31:0];
            if (bit_ff == 6'd0) begin
               busy_ff <= 1'b0; done_ff <= 1'b1;
            end
            bit_ff <= bit_ff - 6'd1;
         end
         if (cmd.emit) begin
            rsp_ff <= rsp_in;
            if (hit) samp_ff <= samp_ff + 64'd1;
            full_ff <= 1'b1;
            done_ff <= 1'b0;
            pos_ff <= '0; ltype_ff <= '0; frag_ff <= '0; dlen_ff <= '0; hdr_ff <= '0;
            proto_ff <= '0; src_ff <= '0; dst_ff <= '0; ports_ff <= '0;
            link_ff <= 1'b0; ifok_ff <= 1'b0; counted_ff <= 1'b0;
         end else if (cmd.rsp_pop) full_ff <= 1'b0;
      end
   end

   assign status.eligible = elig_ff;
   assign status.keep_all = (rate_ff <= 32'd1);
   assign status.div_done = done_ff;
   assign status.rsp_full = full_ff;
   assign rsp = rsp_ff;
endmodule
`default_nettype wire

// File: hdl/ifps_control.sv
// ifps_control: sequencer for byte intake, seed mix, remainder and response
// depends on ifps_pkg
`timescale 1ns / 1ps
`default_nettype none
module ifps_control import ifps_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_last,
   output logic            req_ready,
   input  wire logic       rsp_ready,
   output logic            rsp_valid,
   input  wire status_type status,
   output cmd_type         cmd
);
   localparam logic [1:0] S_BYTES = 2'd0, S_MIX = 2'd1, S_DIV = 2'd2, S_EMIT = 2'd3;
   logic [1:0] state_ff, state_in;
   logic       pop, take;

   always_comb begin
      rsp_valid = status.rsp_full;
      pop = status.rsp_full && rsp_ready;
      req_ready = (state_ff == S_BYTES);
      take = req_valid && req_ready;
      cmd = '0;
      cmd.parse = take;
      cmd.finish = take && req_last;
      cmd.rsp_pop = pop;
      state_in = state_ff;
      case (state_ff)
         S_BYTES: if (take && req_last) state_in = S_MIX;
         S_MIX: begin
            cmd.mul_go = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_start = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: if (status.div_done && (!status.rsp_full || pop)) begin
            cmd.emit = 1'b1;
            state_in = S_BYTES;
         end
         default: state_in = S_BYTES;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_BYTES;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

// File: hdl/ipv4_flow_packet_sampler.sv
// ipv4_flow_packet_sampler: top level, joins controller and datapath
// depends on ifps_pkg, ifps_stream_if, ifps_control, ifps_datapath
`timescale 1ns / 1ps
`default_nettype none
// usage
// - req channel: one captured byte per item plus per-packet side fields
// - rsp channel: exactly one item per packet, sent after its last byte
// - csr port: index 0 sample divisor, index 1 watched interface
// throughput
// - ordinary bytes are taken one per cycle, back to back
// - the last byte starts a seed mix, the lcg multiply with the remainder
//   start, a bit-serial remainder over the 32-bit lcg output and the
//   response load; the next packet's first byte is taken only after the
//   response load
// response
// - the response is valid once the response load has registered it
// reset
// - clears counters, parser state and both csr registers
// stall
// - a held response stays in the output register; the next packet is still
//   taken and its remainder runs, but its response load and any further
//   bytes wait until the receiver takes the held item
module ipv4_flow_packet_sampler import ifps_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   ifps_stream_if.sink      req,
   ifps_stream_if.source    rsp,
   input  wire logic        csr_write,
   input  wire logic [0:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   cmd_type    cmd;
   status_type status;
   logic       ready_w;

   // sequencing of bytes and the per-packet draw
   ifps_control u_control (
      .clock, .reset,
      .req_valid(req.valid), .req_last(req.payload.last_byte), .req_ready(ready_w),
      .rsp_ready(rsp.ready), .rsp_valid(rsp.valid),
      .status, .cmd
   );

   // parser, counters and remainder unit
   ifps_datapath u_datapath (
      .clock, .reset, .req(req.payload),
      .csr_write, .csr_index, .csr_data,
      .cmd, .status, .rsp(rsp.payload)
   );

   assign req.ready = ready_w;
endmodule
`default_nettype wire

// File: hdl/ifps_checker.sv
// ifps_checker: port-level checks for the sampler, bound to the top level
// depends on ifps_pkg
`timescale 1ns / 1ps
`default_nettype none
module ifps_checker import ifps_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    req_last,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_payload
);
   // a stalled response holds its value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");
   // no new byte accepted right after a last byte
   a_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("byte accepted during packet end");
   // a sampled record carries a nonzero sample count
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.event_valid |-> rsp_payload.sampled_total != 64'd0)
      else $error("sample count zero on sampled record");
   // segments of a sampled record are never zero
   a_seg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.event_valid |-> rsp_payload.event_segments != 16'd0)
      else $error("zero segments");
endmodule

bind ipv4_flow_packet_sampler ifps_checker u_checker (
   .clock, .reset,
   .req_valid(req.valid), .req_ready(req.ready), .req_last(req.payload.last_byte),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);
`default_nettype wire

// File: tb/tb_ipv4_flow_packet_sampler.sv
// testbench for the ipv4 flow packet sampler: byte-stream packets in, one record per packet out
// depends on ifps_pkg, ifps_stream_if and the ipv4_flow_packet_sampler rtl
`timescale 1ns / 1ps

// sampler scoreboard: mirrors parser, counters and one-in-n draw, queues expected records
class sampler_scoreboard;
   logic [31:0] divisor;
   logic [15:0] watched_if;
   logic [6:0]  pos;
   logic [15:0] eth_type;
   logic [7:0]  ver_ihl;
   logic [15:0] frag;
   logic [15:0] tot_len;
   logic [7:0]  proto;
   logic [31:0] src_addr;
   logic [31:0] dst_addr;
   logic [31:0] ports;
   logic [63:0] pkt_count;
   logic [63:0] byte_count;
   logic [63:0] smp_count;
   bit eth_path;
   bit if_match;
   bit counted;
   ifps_pkg::rsp_type pending_records[$];
   int errors;

   function new();
      divisor = 0;
      watched_if = 0;
      pkt_count = 0;
      byte_count = 0;
      smp_count = 0;
      errors = 0;
      clear_packet();
   endfunction

   function void clear_packet();
      pos = 0;
      eth_type = 0;
      ver_ihl = 0;
      frag = 0;
      tot_len = 0;
      proto = 0;
      src_addr = 0;
      dst_addr = 0;
      ports = 0;
      eth_path = 0;
      if_match = 0;
      counted = 0;
   endfunction

   function void write_csr(bit idx, logic [31:0] val);
      if (idx == ifps_pkg::CSR_DIVISOR) divisor = val;
      else watched_if = val[15:0];
   endfunction

   // note one accepted byte; queue a record when it ends the packet
   function void note_byte(ifps_pkg::req_type it);
      int p, n, hdr_start, off, ihl4;
      bit link_ok;
      logic [31:0] rate, seed, rnd;
      ifps_pkg::rsp_type r;
      p = pos;
      n = p + 1;
      if (p == 0) begin
         eth_path = it.has_link_header;
         if_match = (watched_if != 0) && (it.if_index == watched_if);
      end
      hdr_start = eth_path ? 14 : 0;
      if (p < 127) begin
         if (eth_path && (p == 12 || p == 13)) eth_type = {eth_type[7:0], it.data_byte};
         if (p >= hdr_start) begin
            off = p - hdr_start;
            ihl4 = ver_ihl[3:0] * 4;
            if (off == 0) ver_ihl = it.data_byte;
            else if (off == 2 || off == 3) tot_len = {tot_len[7:0], it.data_byte};
            else if (off == 6 || off == 7) frag = {frag[7:0], it.data_byte};
            else if (off == 9) proto = it.data_byte;
            else if (off >= 12 && off < 16) src_addr[8*(off-12) +: 8] = it.data_byte;
            else if (off >= 16 && off < 20) dst_addr[8*(off-16) +: 8] = it.data_byte;
            if (ihl4 >= 20 && off >= ihl4 && off < ihl4 + 4)
               ports = {ports[23:0], it.data_byte};
         end
         pos = 7'(n);
      end
      ihl4 = ver_ihl[3:0] * 4;
      link_ok = eth_path ? (eth_type == ifps_pkg::ETH_TYPE_IP)
                         : (if_match && ver_ihl[7:4] == 4);
      if (!counted && link_ok && ihl4 >= 20 && n == hdr_start + ihl4) begin
         counted = 1;
         pkt_count += 1;
         byte_count += it.wire_length;
      end
      if (!it.last_byte) return;
      r = '0;
      if (counted && frag[12:0] == 0 &&
          ((proto == ifps_pkg::PROTO_TCP && n >= hdr_start + ihl4 + 20) ||
           (proto == ifps_pkg::PROTO_UDP && n >= hdr_start + ihl4 + 8))) begin
         rate = (divisor != 0) ? divisor : 32'd100;
         seed = it.entropy ^ src_addr ^ dst_addr ^ ports ^ it.time_low;
         rnd = seed * 32'd1103515245 + 32'd12345;
         if (rate <= 1 || (rnd % rate) == 0) begin
            smp_count += 1;
            r.event_valid = 1;
            r.source_address = src_addr;
            r.dest_address = dst_addr;
            r.source_port = ports[31:16];
            r.dest_port = ports[15:0];
            r.ip_total_length = tot_len;
            r.protocol_number = proto;
            r.event_direction = it.direction;
            r.event_segments = (it.seg_count != 0) ? it.seg_count : 16'd1;
         end
      end
      r.packet_total = pkt_count;
      r.byte_total = byte_count;
      r.sampled_total = smp_count;
      pending_records.push_back(r);
      clear_packet();
   endfunction

   task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task check_record(ifps_pkg::rsp_type got);
      ifps_pkg::rsp_type want;
      if (pending_records.size() == 0) begin
         report("unexpected record", got.packet_total, 0);
         return;
      end
      want = pending_records.pop_front();
      if (got.event_valid !== want.event_valid)
         report("event_valid", got.event_valid, want.event_valid);
      if (got.source_address !== want.source_address)
         report("source_address", got.source_address, want.source_address);
      if (got.dest_address !== want.dest_address)
         report("dest_address", got.dest_address, want.dest_address);
      if (got.source_port !== want.source_port)
         report("source_port", got.source_port, want.source_port);
      if (got.dest_port !== want.dest_port)
         report("dest_port", got.dest_port, want.dest_port);
      if (got.ip_total_length !== want.ip_total_length)
         report("ip_total_length", got.ip_total_length, want.ip_total_length);
      if (got.protocol_number !== want.protocol_number)
         report("protocol_number", got.protocol_number, want.protocol_number);
      if (got.event_direction !== want.event_direction)
         report("event_direction", got.event_direction, want.event_direction);
      if (got.event_segments !== want.event_segments)
         report("event_segments", got.event_segments, want.event_segments);
      if (got.packet_total !== want.packet_total)
         report("packet_total", got.packet_total, want.packet_total);
      if (got.byte_total !== want.byte_total)
         report("byte_total", got.byte_total, want.byte_total);
      if (got.sampled_total !== want.sampled_total)
         report("sampled_total", got.sampled_total, want.sampled_total);
   endtask
endclass

module tb_ipv4_flow_packet_sampler;
   import ifps_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic [0:0]  csr_index;
   logic [31:0] csr_data;

   ifps_stream_if #(.payload_type(req_type)) req_ch ();
   ifps_stream_if #(.payload_type(rsp_type)) rsp_ch ();

   ipv4_flow_packet_sampler dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch.sink),
      .rsp       (rsp_ch.source),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   sampler_scoreboard sb;
   longint cycle_count;
   bit     quiet_tail;       // no idling on either side near the end
   bit     hold_rsp;         // long receiver hold-off request
   byte unsigned pkt_bytes[$];
   int     accepted_items;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // watchdog
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 1500000) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // note accepted bytes and check records, sampled at the edge
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         sb.note_byte(req_ch.payload);
         accepted_items++;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) sb.check_record(rsp_ch.payload);
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      int k;
      rsp_ch.ready = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 0;
            for (k = 0; k < 400; k++) @(posedge clock);
            hold_rsp = 0;
            rsp_ch.ready <= 1;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_ch.ready <= 1;
         end else begin
            rsp_ch.ready <= 1;
         end
      end
   end

   task write_reg(bit idx, logic [31:0] val);
      @(posedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      sb.write_csr(idx, val);
      @(posedge clock);
      csr_write <= 0;
   endtask

   // send one byte, with possible idle gap before it
   task send_byte(req_type it);
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.payload <= it;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // send pkt_bytes as one packet; side fields random, last one marked
   task send_packet(bit eth, logic [15:0] ifx);
      req_type it;
      int i;
      for (i = 0; i < pkt_bytes.size(); i++) begin
         it.data_byte = pkt_bytes[i];
         it.last_byte = (i == pkt_bytes.size() - 1);
         it.has_link_header = ($urandom_range(0, 9) == 0) ? ~eth : eth;
         if (i == 0) it.has_link_header = eth;
         it.direction = 1'($urandom_range(0, 1));
         it.seg_count = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom);
         it.entropy = $urandom;
         it.time_low = $urandom;
         it.wire_length = ($urandom_range(0, 5) == 0) ? 17'h1ffff : 17'($urandom);
         it.if_index = (i == 0) ? ifx : 16'($urandom);
         send_byte(it);
      end
      req_ch.valid <= 0;
      @(posedge clock);
   endtask

   // build a packet: eth header optional, ipv4 header of ihl words but at least five, l4 bytes
   task build_packet(bit eth, logic [15:0] etype, logic [3:0] ver, logic [3:0] ihl,
                     logic [15:0] fragw, logic [7:0] prot, int l4_len, int trunc);
      int i, total;
      pkt_bytes.delete();
      if (eth) begin
         for (i = 0; i < 12; i++) pkt_bytes.push_back(8'($urandom));
         pkt_bytes.push_back(etype[15:8]);
         pkt_bytes.push_back(etype[7:0]);
      end
      pkt_bytes.push_back({ver, ihl});
      pkt_bytes.push_back(8'($urandom));
      pkt_bytes.push_back(8'($urandom));
      pkt_bytes.push_back(8'($urandom));
      pkt_bytes.push_back(8'($urandom));
      pkt_bytes.push_back(8'($urandom));
      pkt_bytes.push_back(fragw[15:8]);
      pkt_bytes.push_back(fragw[7:0]);
      pkt_bytes.push_back(8'($urandom));
      pkt_bytes.push_back(prot);
      for (i = 10; i < 20; i++) pkt_bytes.push_back(8'($urandom));
      for (i = 20; i < ihl * 4; i++) pkt_bytes.push_back(8'($urandom));
      for (i = 0; i < l4_len; i++) pkt_bytes.push_back(8'($urandom));
      total = pkt_bytes.size() - trunc;
      if (total < 1) total = 1;
      while (pkt_bytes.size() > total) void'(pkt_bytes.pop_back());
   endtask

   task wait_drained();
      while (sb.pending_records.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task random_packet(logic [15:0] ifx);
      int sel, i, len;
      bit eth;
      logic [7:0] prot;
      logic [15:0] fw;
      sel = $urandom_range(0, 19);
      eth = 1'($urandom_range(0, 1));
      prot = ($urandom_range(0, 9) < 5) ? PROTO_TCP :
             ($urandom_range(0, 5) < 5) ? PROTO_UDP : 8'($urandom);
      fw = ($urandom_range(0, 5) == 0) ? 16'($urandom) : {3'($urandom), 13'd0};
      if (sel < 2) begin
         // noise packet
         len = $urandom_range(1, 20);
         pkt_bytes.delete();
         for (i = 0; i < len; i++) pkt_bytes.push_back(8'($urandom));
      end else if (sel < 4) begin
         // long packet, which can run past saturation
         build_packet(eth, ETH_TYPE_IP, 4'd4, 4'd5, fw, prot, $urandom_range(100, 110), 0);
      end else begin
         build_packet(eth, ($urandom_range(0, 15) == 0) ? 16'($urandom) : ETH_TYPE_IP,
                      ($urandom_range(0, 15) == 0) ? 4'($urandom) : 4'd4,
                      ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(5, 7)),
                      fw, prot, $urandom_range(0, 20),
                      ($urandom_range(0, 4) == 0) ? $urandom_range(1, 30) : 0);
      end
      send_packet(eth, ($urandom_range(0, 3) == 0) ? 16'($urandom) : ifx);
   endtask

   initial begin
      int i, ph, per_half;
      logic [15:0] ifx;
      sb = new();
      accepted_items = 0;
      quiet_tail = 0;
      hold_rsp = 0;
      reset = 1;
      csr_write = 0;
      csr_index = CSR_DIVISOR;
      csr_data = 0;
      req_ch.valid = 0;
      req_ch.payload = '0;
      repeat (3) @(posedge clock);
      reset <= 0;

      // directed: defaults, watched interface zero rejects raw ip
      build_packet(1'b0, 16'd0, 4'd4, 4'd5, 16'd0, PROTO_TCP, 0, 0);
      send_packet(1'b0, 16'd0);
      wait_drained();
      write_reg(CSR_DIVISOR, 32'd1);
      write_reg(CSR_IFACE, 32'hffff);
      ifx = 16'hffff;
      build_packet(1'b1, ETH_TYPE_IP, 4'd4, 4'd5, 16'd0, PROTO_TCP, 20, 0);
      send_packet(1'b1, 16'd0);
      build_packet(1'b1, ETH_TYPE_IP, 4'd4, 4'd15, 16'd0, PROTO_UDP, 8, 0);
      send_packet(1'b1, 16'd0);
      build_packet(1'b0, 16'd0, 4'd4, 4'd5, 16'd0, PROTO_UDP, 8, 0);
      send_packet(1'b0, ifx);
      build_packet(1'b0, 16'd0, 4'd4, 4'd5, 16'd0, PROTO_UDP, 0, 0);
      send_packet(1'b0, 16'h1234);
      build_packet(1'b0, 16'd0, 4'd6, 4'd5, 16'd0, PROTO_TCP, 0, 0);
      send_packet(1'b0, ifx);
      build_packet(1'b1, 16'h86dd, 4'd4, 4'd5, 16'd0, PROTO_TCP, 0, 0);
      send_packet(1'b1, 16'd0);
      build_packet(1'b1, ETH_TYPE_IP, 4'd4, 4'd5, 16'h2001, PROTO_TCP, 0, 0);
      send_packet(1'b1, 16'd0);
      build_packet(1'b1, ETH_TYPE_IP, 4'd4, 4'd5, 16'h4000, PROTO_TCP, 20, 0);
      send_packet(1'b1, 16'd0);
      build_packet(1'b1, ETH_TYPE_IP, 4'd4, 4'd5, 16'd0, 8'd1, 0, 0);
      send_packet(1'b1, 16'd0);
      build_packet(1'b1, ETH_TYPE_IP, 4'd4, 4'd5, 16'd0, PROTO_TCP, 20, 1);
      send_packet(1'b1, 16'd0);
      build_packet(1'b1, ETH_TYPE_IP, 4'd4, 4'd5, 16'd0, PROTO_UDP, 8, 1);
      send_packet(1'b1, 16'd0);
      build_packet(1'b1, ETH_TYPE_IP, 4'd4, 4'd5, 16'd0, PROTO_TCP, 0, 1);
      send_packet(1'b1, 16'd0);
      build_packet(1'b1, ETH_TYPE_IP, 4'd4, 4'd3, 16'd0, PROTO_TCP, 0, 0);
      send_packet(1'b1, 16'd0);
      build_packet(1'b0, 16'd0, 4'd4, 4'd0, 16'd0, PROTO_UDP, 0, 0);
      send_packet(1'b0, ifx);
      build_packet(1'b1, ETH_TYPE_IP, 4'd4, 4'd5, 16'd0, PROTO_TCP, 100, 0);
      send_packet(1'b1, 16'd0);
      pkt_bytes = '{8'hff}; send_packet(1'b0, ifx);
      pkt_bytes = '{8'h00}; send_packet(1'b1, ifx);

      // random phases through several register settings
      for (ph = 0; ph < 6; ph++) begin
         wait_drained();
         case (ph)
            0: write_reg(CSR_DIVISOR, 32'd0);
            1: write_reg(CSR_DIVISOR, 32'd2);
            2: write_reg(CSR_DIVISOR, 32'hffffffff);
            3: write_reg(CSR_DIVISOR, 32'd3);
            4: write_reg(CSR_DIVISOR, 32'd1);
            default: write_reg(CSR_DIVISOR, 32'd7);
         endcase
         ifx = (ph == 2) ? 16'd1 : 16'($urandom_range(1, 65535));
         write_reg(CSR_IFACE, ifx);
         per_half = (ph == 1) ? 3 : 1;
         if (ph == 1) hold_rsp = 1;
         if (ph == 5) quiet_tail = 1;
         for (i = 0; i < per_half; i++) random_packet(ifx);
         if (ph == 3) wait_drained();   // sender pause until all records are in
         for (i = 0; i < per_half; i++) random_packet(ifx);
      end

      wait_drained();
      if (sb.errors == 0 && sb.pending_records.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

// File: files.f
hdl/ifps_pkg.sv
hdl/ifps_if.sv
hdl/ifps_datapath.sv
hdl/ifps_control.sv
hdl/ipv4_flow_packet_sampler.sv
hdl/ifps_checker.sv
tb/tb_ipv4_flow_packet_sampler.sv
